// ===== src/blc_pkg.sv =====
package blc_pkg;

  // Default channel count
  localparam int NUM_LEDS_DEF = 8;

  // Field widths
  localparam int RELOAD_W = 13;
  localparam int BLINK_W  = 8;
  localparam int TIME_W   = 16;
  localparam int PINS_W   = 8;

  // Repeat count that never runs down
  localparam logic [BLINK_W-1:0] BLINK_FOREVER = 8'hff;

  // ms to 10 ms ticks: x / 10 == (x * 52429) >> 19 for every 16-bit x
  localparam logic [TIME_W:0] DIV10_MUL   = 17'd52429;
  localparam int              DIV10_SHIFT = 19;

  typedef enum logic [1:0] {
    ACT_TICK,
    ACT_SET,
    ACT_OFF,
    ACT_NONE
  } act_t;

  typedef enum logic [1:0] {
    MODE_OFF,
    MODE_ON,
    MODE_BLINK
  } mode_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RD,
    S_WB,
    S_DONE
  } state_t;

  // One LED's stored record; all-zero is the reset value
  typedef struct packed {
    mode_t               led_mode;
    mode_t               saved_mode;
    logic                lit;
    logic [RELOAD_W-1:0] on_cd;
    logic [RELOAD_W-1:0] off_cd;
    logic [RELOAD_W-1:0] on_rl;
    logic [RELOAD_W-1:0] off_rl;
    logic [BLINK_W-1:0]  blinks;
  } led_entry_t;

  // Update request for one record
  typedef struct packed {
    act_t                act;
    mode_t               mode;
    logic [RELOAD_W-1:0] on_rl;
    logic [RELOAD_W-1:0] off_rl;
    logic [BLINK_W-1:0]  reps;
    logic                start;
    logic                polarity;
  } step_req_t;

  // Updated record plus pin drive
  typedef struct packed {
    led_entry_t entry;
    logic       drive;
    logic       level;
  } step_res_t;

endpackage

// ===== src/blc_mem.sv =====
module blc_mem #(
  parameter int DEPTH = blc_pkg::NUM_LEDS_DEF,
  parameter int AW    = 3
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   rd_en,
  input  logic [AW-1:0]          rd_addr,
  output blc_pkg::led_entry_t    rd_data,
  input  logic                   wr_en,
  input  logic [AW-1:0]          wr_addr,
  input  blc_pkg::led_entry_t    wr_data
);
  import blc_pkg::*;

  led_entry_t           mem [DEPTH];
  led_entry_t           rd_data_r;
  logic                 rd_vld_r;
  logic [DEPTH-1:0]     vld_r;

  // Record store, one write and one read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // Per-entry valid bits; an unwritten entry reads as reset value
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_r <= vld_r[rd_addr];
      end
    end
  end

  assign rd_data = rd_vld_r ? rd_data_r : '0;

endmodule

// ===== src/blc_step.sv =====
module blc_step (
  input  blc_pkg::led_entry_t entry,
  input  blc_pkg::step_req_t  req,
  output blc_pkg::step_res_t  res
);
  import blc_pkg::*;

  led_entry_t e;
  logic       drive;
  logic       lit_lvl;

  // Next record for one LED
  always_comb begin
    e       = entry;
    drive   = 1'b0;
    lit_lvl = 1'b0;
    case (req.act)
      ACT_TICK: begin
        case (entry.led_mode)
          MODE_BLINK: begin
            if (entry.blinks != '0) begin
              if (!entry.lit) begin
                if (entry.off_cd == '0) begin
                  drive   = 1'b1;
                  lit_lvl = 1'b1;
                  e.on_cd = entry.on_rl;
                  e.lit   = 1'b1;
                end
              end else if (entry.on_cd == '0) begin
                // off edge: one blink done
                drive    = 1'b1;
                lit_lvl  = 1'b0;
                e.off_cd = entry.off_rl;
                e.lit    = 1'b0;
                if (entry.blinks != BLINK_FOREVER) begin
                  e.blinks = entry.blinks - BLINK_W'(1);
                end
              end
              if (e.on_cd != '0) begin
                e.on_cd = e.on_cd - RELOAD_W'(1);
              end
              if (e.off_cd != '0) begin
                e.off_cd = e.off_cd - RELOAD_W'(1);
              end
            end else begin
              e.led_mode = entry.saved_mode;
            end
          end
          MODE_ON: begin
            if (!entry.lit) begin
              drive   = 1'b1;
              lit_lvl = 1'b1;
              e.lit   = 1'b1;
            end
          end
          default: begin
            if (entry.lit) begin
              drive   = 1'b1;
              lit_lvl = 1'b0;
              e.lit   = 1'b0;
            end
          end
        endcase
      end
      ACT_SET: begin
        if (entry.led_mode != MODE_BLINK) begin
          e.saved_mode = entry.led_mode;
        end
        e.led_mode = req.mode;
        e.on_cd    = '0;
        e.off_cd   = '0;
        e.on_rl    = req.on_rl;
        e.off_rl   = req.off_rl;
        e.blinks   = req.reps;
        e.lit      = req.start;
      end
      ACT_OFF: begin
        if (entry.led_mode != MODE_OFF) begin
          e.led_mode = MODE_OFF;
          e.on_cd    = '0;
          e.off_cd   = '0;
          e.on_rl    = '0;
          e.off_rl   = '0;
          e.blinks   = '0;
        end
      end
      default: begin
      end
    endcase
  end

  assign res.entry = e;
  assign res.drive = drive;
  assign res.level = lit_lvl ^ req.polarity;

endmodule

// ===== src/led_blink_pattern_controller.sv =====
// LED blink pattern engine for up to NUM_LEDS channels.
// Input channel (in_valid/in_ready): one word per action - a 10 ms tick, a
// set of one LED's mode, times and repeat count, or an off for one LED.
// Output channel (out_valid/out_ready): one word per action carrying the
// pin levels of LEDs 0..7 after that action.
// cfg_wr_en/cfg_active_low_mask write the pin polarity mask; write it only
// while the block is idle.
// Sequencing: a word is taken only when the engine is idle. A tick reads and
// rewrites every LED record in turn through the record store's single
// read and write port; set and off read and rewrite one record. Code 3
// actions and out-of-range LEDs touch no record. The next word is taken
// only after the result of the last one is loaded into the output register.
// Reset (synchronous, rst_n low) clears every record, the pins, the mask
// and the output valid flag. If the receiver stalls, the result is held in
// the output register and the engine may take the next word; it waits to
// finish that word until the held result is taken.
module led_blink_pattern_controller #(
  parameter int NUM_LEDS = blc_pkg::NUM_LEDS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    in_action,
  input  logic [2:0]                    in_led_index,
  input  logic [1:0]                    in_mode,
  input  logic [blc_pkg::TIME_W-1:0]    in_on_time_ms,
  input  logic [blc_pkg::TIME_W-1:0]    in_off_time_ms,
  input  logic [blc_pkg::BLINK_W-1:0]   in_repeat_count,
  input  logic                          in_start_lit,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [blc_pkg::PINS_W-1:0]    out_pin_levels,
  input  logic                          cfg_wr_en,
  input  logic [blc_pkg::PINS_W-1:0]    cfg_active_low_mask
);
  import blc_pkg::*;

  localparam int AW = (NUM_LEDS > 1) ? $clog2(NUM_LEDS) : 1;
  localparam logic [AW-1:0] LAST_LED = AW'(NUM_LEDS - 1);

  state_t               state_r, state_nxt;
  logic [AW-1:0]        cnt_r, cnt_nxt;

  act_t                 act_r;
  logic [2:0]           idx_r;
  logic [1:0]           mode_r;
  logic [TIME_W-1:0]    on_ms_r, off_ms_r;
  logic [BLINK_W-1:0]   reps_r;
  logic                 start_r;
  logic [RELOAD_W-1:0]  on_q_r, off_q_r;
  logic [TIME_W+16:0]   on_prod, off_prod;

  logic [PINS_W-1:0]    mask_r;
  logic [NUM_LEDS-1:0]  pins_r;
  logic                 out_valid_r;
  logic [PINS_W-1:0]    out_levels_r;
  logic [PINS_W-1:0]    levels;

  logic                 accept;
  logic                 idx_ok;
  logic [AW-1:0]        idx_addr;
  logic                 rd_en, wr_en, out_load;
  logic [AW-1:0]        rd_addr, wr_addr;
  led_entry_t           rd_data;
  step_req_t            req;
  step_res_t            res;
  mode_t                req_mode;
  logic                 polarity;

  assign accept   = in_valid && in_ready;
  assign in_ready = (state_r == S_IDLE);
  assign idx_ok   = (int'(idx_r) < NUM_LEDS);
  assign idx_addr = AW'(idx_r);
  assign wr_addr  = (act_r == ACT_TICK) ? cnt_r : idx_addr;

  // Input word capture
  always_ff @(posedge clk) begin
    if (accept) begin
      act_r    <= act_t'(in_action);
      idx_r    <= in_led_index;
      mode_r   <= in_mode;
      on_ms_r  <= in_on_time_ms;
      off_ms_r <= in_off_time_ms;
      reps_r   <= in_repeat_count;
      start_r  <= in_start_lit;
    end
  end

  // Divide by ten via reciprocal multiply, registered before use
  assign on_prod  = {17'b0, on_ms_r} * {16'b0, DIV10_MUL};
  assign off_prod = {17'b0, off_ms_r} * {16'b0, DIV10_MUL};

  always_ff @(posedge clk) begin
    if (state_r == S_RD) begin
      on_q_r  <= on_prod[DIV10_SHIFT +: RELOAD_W];
      off_q_r <= off_prod[DIV10_SHIFT +: RELOAD_W];
    end
  end

  // Polarity mask
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r <= '0;
    end else if (cfg_wr_en) begin
      mask_r <= cfg_active_low_mask;
    end
  end

  // Polarity of the LED being written; LEDs from 8 up are active high
  always_comb begin
    polarity = 1'b0;
    for (int i = 0; i < PINS_W; i++) begin
      if (i < NUM_LEDS && wr_addr == AW'(i)) begin
        polarity = mask_r[i];
      end
    end
  end

  // Mode code 3 is stored as off
  always_comb begin
    case (mode_r)
      MODE_ON:    req_mode = MODE_ON;
      MODE_BLINK: req_mode = MODE_BLINK;
      default:    req_mode = MODE_OFF;
    endcase
  end

  assign req.act      = act_r;
  assign req.mode     = req_mode;
  assign req.on_rl    = on_q_r;
  assign req.off_rl   = off_q_r;
  assign req.reps     = reps_r;
  assign req.start    = start_r;
  assign req.polarity = polarity;

  blc_mem #(
    .DEPTH (NUM_LEDS),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (res.entry)
  );

  blc_step u_step (
    .entry (rd_data),
    .req   (req),
    .res   (res)
  );

  // Sequencer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // Read, update, write back; ticks overlap read of i+1 with write of i
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    rd_en     = 1'b0;
    rd_addr   = cnt_r;
    wr_en     = 1'b0;
    out_load  = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_RD;
          cnt_nxt   = '0;
        end
      end
      S_RD: begin
        if (act_r == ACT_TICK) begin
          rd_en     = 1'b1;
          rd_addr   = cnt_r;
          state_nxt = S_WB;
        end else if ((act_r == ACT_SET || act_r == ACT_OFF) && idx_ok) begin
          rd_en     = 1'b1;
          rd_addr   = idx_addr;
          state_nxt = S_WB;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_WB: begin
        wr_en = 1'b1;
        if (act_r == ACT_TICK && cnt_r != LAST_LED) begin
          rd_en   = 1'b1;
          rd_addr = AW'(cnt_r + 1'b1);
          cnt_nxt = AW'(cnt_r + 1'b1);
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Pin levels
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pins_r <= '0;
    end else if (wr_en && res.drive) begin
      pins_r[wr_addr] <= res.level;
    end
  end

  for (genvar g = 0; g < PINS_W; g++) begin : g_levels
    if (g < NUM_LEDS) begin : g_pin
      assign levels[g] = pins_r[g];
    end else begin : g_none
      assign levels[g] = 1'b0;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_levels_r <= levels;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_pin_levels = out_levels_r;

  // Read and write never hit the same record in one cycle
  a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
    (rd_en && wr_en) |-> (rd_addr != wr_addr))
    else $error("record read and write to the same LED");

  // Pins only move on a write-back cycle
  a_pins_on_wb: assert property (@(posedge clk) disable iff (!rst_n)
    (pins_r != $past(pins_r)) |-> ($past(state_r) == S_WB))
    else $error("pin level changed outside write-back");

  // A tick sweep writes consecutive LEDs
  a_tick_order: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WB && act_r == ACT_TICK && $past(state_r) == S_WB)
      |-> (wr_addr == AW'($past(wr_addr) + 1'b1)))
    else $error("tick sweep skipped an LED");

  // A result is only loaded once the output register is free
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> (!out_valid_r || out_ready))
    else $error("result overwritten before it was taken");

endmodule
